FILE: hdl/aes_key_expansion_top_macros.svh
// Assertion macros shared by the key expansion RTL.
`ifndef AES_KEY_EXPANSION_TOP_MACROS_SVH
`define AES_KEY_EXPANSION_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define AKE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AKE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AKE_ASSERT(label, clk, rst, prop, msg)
`define AKE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: hdl/aeske_pkg.sv
package aeske_pkg;

  localparam int BLOCK_WORDS   = 4;
  localparam int MAX_KEY_WORDS = 8;
  localparam int ADDR_W        = $clog2(MAX_KEY_WORDS);
  localparam int IDX_W         = 6;
  localparam int WORD_W        = 32;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;
  localparam logic [1:0] MODE_256 = 2'd2;

  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] RCON_POLY = 8'h1b;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [WORD_W-1:0] rot_word(input logic [WORD_W-1:0] x);
    return {x[23:0], x[31:24]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? RCON_POLY : 8'h00);
  endfunction

  function automatic logic [3:0] key_words(input logic [1:0] mode);
    logic [3:0] nk;
    unique case (mode)
      MODE_128: nk = 4'd4;
      MODE_192: nk = 4'd6;
      default:  nk = 4'(MAX_KEY_WORDS);
    endcase
    return nk;
  endfunction

  function automatic logic [IDX_W-1:0] last_index(input logic [1:0] mode);
    logic [IDX_W-1:0] idx;
    unique case (mode)
      MODE_128: idx = IDX_W'(BLOCK_WORDS * (4 + 7) - 1);
      MODE_192: idx = IDX_W'(BLOCK_WORDS * (6 + 7) - 1);
      default:  idx = IDX_W'(BLOCK_WORDS * (MAX_KEY_WORDS + 7) - 1);
    endcase
    return idx;
  endfunction

endpackage

FILE: hdl/aes_key_expansion_top.sv
// Channel   Direction  Handshake            Payload
// key       in         in_valid/in_ready    key_word
// round     out        out_valid/out_ready  round_key_word, word_index, last_word
// config    in         cfg_we               cfg_wdata (key_size_mode)
//
// Each key word is echoed as a round-key word.
// After the last key word, one expanded word is produced per cycle while the output
// is not stalled, 40, 46 or 52 in all, paced by the key window read-modify-write.
// Reset clears the key window and restarts key loading with a 128-bit key.
// A stalled output holds generation; no key word is accepted during generation.
`include "aes_key_expansion_top_macros.svh"

module aes_key_expansion_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] key_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] round_key_word,
  output logic [5:0]  word_index,
  output logic        last_word
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_GEN  = 1'b1;

  localparam int AW = aeske_pkg::ADDR_W;
  localparam int IW = aeske_pkg::IDX_W;

  logic          state;
  logic [1:0]    mode;
  logic [AW-1:0] load_cnt;
  logic [AW-1:0] gen_pos;
  logic [IW-1:0] gen_idx;
  logic [7:0]    rcon;
  logic [31:0]   prev;

  logic [3:0]    nk;
  logic [AW-1:0] nk_m1;
  logic [IW-1:0] last_idx;
  logic [AW-1:0] load_pos;
  logic [AW-1:0] gen_pos_inc;
  logic          slot_free;
  logic          key_acc;
  logic          key_last;
  logic          gen_fire;
  logic          gen_last;
  logic [31:0]   temp;
  logic [31:0]   gen_w;
  logic [31:0]   rdata;

  aeske_pkg::mem_req_t mem_req;

  assign nk          = aeske_pkg::key_words(mode);
  assign nk_m1       = AW'(nk - 4'd1);
  assign last_idx    = aeske_pkg::last_index(mode);
  assign load_pos    = ({1'b0, load_cnt} >= nk) ? '0 : load_cnt;
  assign gen_pos_inc = (gen_pos == nk_m1) ? '0 : AW'(gen_pos + 1'b1);

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_LOAD) && slot_free;
  assign key_acc   = in_valid && in_ready;
  assign key_last  = (load_pos == nk_m1);
  assign gen_fire  = (state == ST_GEN) && slot_free;
  assign gen_last  = (gen_idx == last_idx);

  always_comb begin
    if (gen_pos == '0) begin
      temp = aeske_pkg::sub_word(aeske_pkg::rot_word(prev)) ^ {rcon, 24'h000000};
    end else if (nk == 4'(aeske_pkg::MAX_KEY_WORDS) && gen_pos == AW'(4)) begin
      temp = aeske_pkg::sub_word(prev);
    end else begin
      temp = prev;
    end
  end

  assign gen_w = rdata ^ temp;

  always_comb begin
    mem_req.wr_en   = key_acc || gen_fire;
    mem_req.wr_addr = key_acc ? load_pos : gen_pos;
    mem_req.wr_data = key_acc ? key_word : gen_w;
    mem_req.rd_en   = (key_acc && key_last) || (gen_fire && !gen_last);
    mem_req.rd_addr = key_acc ? '0 : gen_pos_inc;
  end

  aeske_window_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      mode      <= aeske_pkg::MODE_128;
      load_cnt  <= '0;
      gen_pos   <= '0;
      gen_idx   <= '0;
      rcon      <= aeske_pkg::RCON_INIT;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode     <= cfg_wdata;
        load_cnt <= '0;
        rcon     <= aeske_pkg::RCON_INIT;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (key_acc) begin
        out_valid <= 1'b1;
        if (key_last) begin
          state    <= ST_GEN;
          load_cnt <= '0;
          gen_pos  <= '0;
          gen_idx  <= IW'(nk);
        end else begin
          load_cnt <= AW'(load_pos + 1'b1);
        end
      end
      if (gen_fire) begin
        out_valid <= 1'b1;
        gen_pos   <= gen_pos_inc;
        gen_idx   <= IW'(gen_idx + 1'b1);
        if (gen_pos == '0) begin
          rcon <= aeske_pkg::xtime(rcon);
        end
        if (gen_last) begin
          state <= ST_LOAD;
          rcon  <= aeske_pkg::RCON_INIT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_acc) begin
      prev           <= key_word;
      round_key_word <= key_word;
      word_index     <= IW'(load_pos);
      last_word      <= 1'b0;
    end else if (gen_fire) begin
      prev           <= gen_w;
      round_key_word <= gen_w;
      word_index     <= gen_idx;
      last_word      <= gen_last;
    end
  end

  `AKE_ASSERT(a_rw_distinct, clk, rst, (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr), "Key window read and write hit the same entry.")
  `AKE_ASSERT(a_pos_in_range, clk, rst, (state == ST_GEN) |-> ({1'b0, gen_pos} < nk), "Window position beyond key length.")
  `AKE_ASSERT(a_enter_gen, clk, rst, (key_acc && key_last) |=> (state == ST_GEN && gen_pos == '0 && rcon == aeske_pkg::RCON_INIT), "Generation did not start cleanly.")
  `AKE_ASSERT(a_end_gen, clk, rst, (gen_fire && gen_last) |=> (state == ST_LOAD && last_word && out_valid), "Schedule end not flagged.")

endmodule

FILE: hdl/aeske_window_mem.sv
module aeske_window_mem (
  input  logic                                clk,
  input  logic                                rst,
  input  aeske_pkg::mem_req_t                 req,
  output logic [aeske_pkg::WORD_W-1:0]        rdata
);

  logic [aeske_pkg::WORD_W-1:0]        mem [aeske_pkg::MAX_KEY_WORDS];
  logic [aeske_pkg::MAX_KEY_WORDS-1:0] valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= valid[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

endmodule
